@@ rtl/snapshot_rle_decoder_assert.svh @@
// Assertion macros for the snapshot RLE decoder.
`ifndef SNAPSHOT_RLE_DECODER_ASSERT_SVH
`define SNAPSHOT_RLE_DECODER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define SRD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/srd_pkg.sv @@
// Package for the snapshot RLE decoder: codes, result type and constants.
`timescale 1ns / 1ps
`default_nettype none
package srd_pkg;

  localparam logic [7:0]  ESC_BYTE      = 8'hED;
  localparam logic [15:0] BLK_LEN_RESET = 16'd16384;

  localparam logic [1:0] CMD_DATA   = 2'd0;
  localparam logic [1:0] CMD_END    = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_NORMAL    = 5'b00010,
    PH_GOT_ESC   = 5'b00100,
    PH_GOT_ESC2  = 5'b01000,
    PH_GOT_COUNT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        last;
    logic        ok;
    logic        done;
    logic [7:0]  len;
    logic [15:0] start;
    logic [7:0]  value;
  } result_t;

  function automatic result_t mk_result(input logic [7:0] value, input logic [15:0] start,
                                        input logic [7:0] len, input logic done,
                                        input logic ok, input logic last);
    result_t r;
    r.value = value;
    r.start = start;
    r.len   = len;
    r.done  = done;
    r.ok    = done & ok;
    r.last  = last;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/snapshot_rle_decoder.sv @@
// Top level of the snapshot RLE decoder: byte decoder and result queue.
`timescale 1ns / 1ps
`default_nettype none
// Takes one compressed byte (or an end / start command) per transaction and
// turns it into run descriptors (value, start offset, length) for a block of
// cfg-programmed length; one item per clock is taken while at least two slots
// of the four-entry result queue are free. Results appear in the cycle after
// their item and drain at one per clock while out_tready is high. An
// item makes at most two results, and only after an ED that made none, so with
// out_tready held high the input never stalls. Write cfg only while idle.
module snapshot_rle_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // block_length
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // data_byte[7:0]
  input  wire logic [1:0]  in_tuser,    // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // run_value[7:0], run_start[23:8],
                                        // run_length[31:24], block_done[32],
                                        // block_ok[33], zero[39:34]
  output logic             out_tlast    // last
);

  localparam logic [srd_pkg::QPTR_W:0] QFILL_MAX = (srd_pkg::QPTR_W + 1)'(srd_pkg::QUEUE_DEPTH);
  localparam logic [srd_pkg::QPTR_W:0] QFILL_TWO = (srd_pkg::QPTR_W + 1)'(2);

  logic [15:0]            bl_r;
  srd_pkg::phase_t        phase_r, phase_nxt;
  logic [15:0]            wc_r, wc_nxt;
  logic [7:0]             pc_r, pc_nxt;

  srd_pkg::result_t       queue_r [srd_pkg::QUEUE_DEPTH];
  logic [srd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [srd_pkg::QPTR_W:0]   fill_r;

  logic                   acc, pop, push0, push1;
  srd_pkg::result_t       r0, r1;
  logic                   full;
  logic [15:0]            room;
  logic [7:0]             run_len, run_n;
  logic                   run_done;
  srd_pkg::result_t       head;

  assign acc       = in_tvalid & in_tready;
  assign pop       = out_tvalid & out_tready;
  assign in_tready = rst_n & (fill_r <= QFILL_TWO);

  assign full    = (wc_r >= bl_r);
  assign room    = bl_r - wc_r;
  assign run_len = (phase_r == srd_pkg::PH_GOT_COUNT) ? pc_r : 8'd1;
  assign run_done = ({8'h00, run_len} >= room);
  assign run_n    = run_done ? room[7:0] : run_len;

  always_comb begin
    phase_nxt = phase_r;
    wc_nxt    = wc_r;
    pc_nxt    = pc_r;
    push0     = 1'b0;
    push1     = 1'b0;
    r0        = '0;
    r1        = '0;
    if (acc) begin
      priority if (in_tuser == srd_pkg::CMD_START) begin
        phase_nxt = srd_pkg::PH_NORMAL;
        wc_nxt    = 16'd0;
        pc_nxt    = 8'd0;
        if (bl_r == 16'd0) begin
          push0     = 1'b1;
          r0        = srd_pkg::mk_result(8'd0, 16'd0, 8'd0, 1'b1, 1'b1, 1'b1);
          phase_nxt = srd_pkg::PH_IDLE;
        end
      end else if (in_tuser == srd_pkg::CMD_UNUSED || phase_r == srd_pkg::PH_IDLE) begin
        phase_nxt = phase_r;
      end else if (full) begin
        push0     = 1'b1;
        r0        = srd_pkg::mk_result(8'd0, wc_r, 8'd0, 1'b1, 1'b1, 1'b1);
        phase_nxt = srd_pkg::PH_IDLE;
      end else if (in_tuser == srd_pkg::CMD_END) begin
        push0     = 1'b1;
        phase_nxt = srd_pkg::PH_IDLE;
        if (phase_r == srd_pkg::PH_GOT_ESC) begin
          r0     = srd_pkg::mk_result(srd_pkg::ESC_BYTE, wc_r, 8'd1, 1'b1, 1'b1, 1'b1);
          wc_nxt = wc_r + 16'd1;
        end else begin
          r0 = srd_pkg::mk_result(8'd0, wc_r, 8'd0, 1'b1, (wc_r != 16'd0), 1'b1);
        end
      end else begin
        unique case (phase_r)
          srd_pkg::PH_NORMAL: begin
            if (in_tdata == srd_pkg::ESC_BYTE) begin
              phase_nxt = srd_pkg::PH_GOT_ESC;
            end else begin
              push0  = 1'b1;
              r0     = srd_pkg::mk_result(in_tdata, wc_r, run_n, run_done, 1'b1, 1'b1);
              wc_nxt = wc_r + {8'h00, run_n};
              if (run_done) phase_nxt = srd_pkg::PH_IDLE;
            end
          end
          srd_pkg::PH_GOT_ESC: begin
            if (in_tdata == srd_pkg::ESC_BYTE) begin
              phase_nxt = srd_pkg::PH_GOT_ESC2;
            end else begin
              push0 = 1'b1;
              if (run_done) begin
                // ED fills the block; the following byte is dropped
                r0        = srd_pkg::mk_result(srd_pkg::ESC_BYTE, wc_r, 8'd1, 1'b1, 1'b1,
                                               1'b1);
                wc_nxt    = wc_r + 16'd1;
                phase_nxt = srd_pkg::PH_IDLE;
              end else begin
                push1     = 1'b1;
                r0        = srd_pkg::mk_result(srd_pkg::ESC_BYTE, wc_r, 8'd1, 1'b0, 1'b1,
                                               1'b0);
                r1        = srd_pkg::mk_result(in_tdata, wc_r + 16'd1, 8'd1,
                                               (room == 16'd2), 1'b1, 1'b1);
                wc_nxt    = wc_r + 16'd2;
                phase_nxt = (room == 16'd2) ? srd_pkg::PH_IDLE : srd_pkg::PH_NORMAL;
              end
            end
          end
          srd_pkg::PH_GOT_ESC2: begin
            if (in_tdata == 8'd0) begin
              push0     = 1'b1;
              r0        = srd_pkg::mk_result(8'd0, wc_r, 8'd0, 1'b1, (wc_r != 16'd0), 1'b1);
              phase_nxt = srd_pkg::PH_IDLE;
            end else begin
              pc_nxt    = in_tdata;
              phase_nxt = srd_pkg::PH_GOT_COUNT;
            end
          end
          srd_pkg::PH_GOT_COUNT: begin
            push0     = 1'b1;
            r0        = srd_pkg::mk_result(in_tdata, wc_r, run_n, run_done, 1'b1, 1'b1);
            wc_nxt    = wc_r + {8'h00, run_n};
            pc_nxt    = 8'd0;
            phase_nxt = run_done ? srd_pkg::PH_IDLE : srd_pkg::PH_NORMAL;
          end
          default: begin
            phase_nxt = srd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_r     <= srd_pkg::BLK_LEN_RESET;
      phase_r  <= srd_pkg::PH_IDLE;
      wc_r     <= 16'd0;
      pc_r     <= 8'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (cfg_we) bl_r <= cfg_wdata;
      phase_r  <= phase_nxt;
      wc_r     <= wc_nxt;
      pc_r     <= pc_nxt;
      wr_ptr_r <= wr_ptr_r + srd_pkg::QPTR_W'({1'b0, push0} + {1'b0, push1});
      rd_ptr_r <= rd_ptr_r + srd_pkg::QPTR_W'(pop);
      fill_r   <= fill_r + (srd_pkg::QPTR_W + 1)'(push0) + (srd_pkg::QPTR_W + 1)'(push1)
                  - (srd_pkg::QPTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) queue_r[wr_ptr_r] <= r0;
    if (push1) queue_r[wr_ptr_r + srd_pkg::QPTR_W'(1)] <= r1;
  end

  assign head       = queue_r[rd_ptr_r];
  assign out_tvalid = (fill_r != '0);
  assign out_tdata  = {6'b000000, head.ok, head.done, head.len, head.start, head.value};
  assign out_tlast  = head.last;

  `include "snapshot_rle_decoder_assert.svh"

  `SRD_ASSERT_ALWAYS(a_fill_bound, fill_r <= QFILL_MAX, "result queue overflow")
  `SRD_ASSERT_NEXT(a_start_clears, acc && in_tuser == srd_pkg::CMD_START, wc_r == 16'd0, "start did not clear count")
  `SRD_ASSERT_NEXT(a_done_idles, (push0 && r0.done) || (push1 && r1.done), phase_r == srd_pkg::PH_IDLE, "finished block not idle")

endmodule
`default_nettype wire

@@ test/tb_snapshot_rle_decoder.sv @@
// Self-checking testbench for the snapshot RLE decoder: directed and random streams.
`timescale 1ns / 1ps
module tb_snapshot_rle_decoder;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } stream_item_t;

  localparam int RX_OPEN   = 0;
  localparam int RX_MOSTLY = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_COMB   = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  // decoder state as predicted
  logic [15:0]     blk_len = srd_pkg::BLK_LEN_RESET;
  srd_pkg::phase_t blk_phase = srd_pkg::PH_IDLE;
  logic [15:0]     blk_written = '0;
  logic [7:0]      run_count = '0;

  srd_pkg::result_t item_res[$];
  srd_pkg::result_t runs_due[$];
  stream_item_t     feed_q[$];
  stream_item_t     cur_item;
  srd_pkg::result_t seen_run;
  srd_pkg::result_t due_run;

  int  items_queued = 0;
  int  items_taken = 0;
  bit  item_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  bit  long_hold = 1'b0;
  int  hold_left = 0;
  int  rx_mode = RX_OPEN;
  int  rx_mode_left = 0;
  int  rx_cycle = 0;
  int  fail_count = 0;

  snapshot_rle_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void add_run(input logic [7:0] value, input logic [7:0] len);
    logic [16:0]      room;
    logic [16:0]      n;
    srd_pkg::result_t r;
    if (blk_written >= blk_len || len == 8'd0) return;
    room = {1'b0, blk_len} - {1'b0, blk_written};
    n = ({9'd0, len} < room) ? {9'd0, len} : room;
    r = '0;
    r.value = value;
    r.start = blk_written;
    r.len   = n[7:0];
    r.done  = ({1'b0, blk_written} + n >= {1'b0, blk_len});
    r.ok    = r.done;
    item_res.push_back(r);
    blk_written = blk_written + n[15:0];
    if (r.done) blk_phase = srd_pkg::PH_IDLE;
  endfunction

  function automatic void close_block(input logic ok);
    srd_pkg::result_t r;
    r = '0;
    r.start = blk_written;
    r.done  = 1'b1;
    r.ok    = ok;
    item_res.push_back(r);
    blk_phase = srd_pkg::PH_IDLE;
  endfunction

  function automatic void decode_item(input logic [1:0] cmd, input logic [7:0] b);
    srd_pkg::result_t r;
    item_res.delete();
    if (cmd == srd_pkg::CMD_START) begin
      blk_phase = srd_pkg::PH_NORMAL;
      blk_written = '0;
      run_count = '0;
      if (blk_written >= blk_len) close_block(1'b1);
    end else if (cmd == srd_pkg::CMD_UNUSED || blk_phase == srd_pkg::PH_IDLE) begin
    end else if (blk_written >= blk_len) begin
      close_block(1'b1);
    end else if (cmd == srd_pkg::CMD_END) begin
      if (blk_phase == srd_pkg::PH_GOT_ESC) begin
        // lone escape is flushed and always counts as success
        r = '0;
        r.value = srd_pkg::ESC_BYTE;
        r.start = blk_written;
        r.len   = 8'd1;
        r.done  = 1'b1;
        r.ok    = 1'b1;
        item_res.push_back(r);
        blk_written = blk_written + 16'd1;
        blk_phase = srd_pkg::PH_IDLE;
      end else begin
        close_block(blk_written != 16'd0);
      end
    end else begin
      case (blk_phase)
        srd_pkg::PH_NORMAL: begin
          if (b == srd_pkg::ESC_BYTE) blk_phase = srd_pkg::PH_GOT_ESC;
          else add_run(b, 8'd1);
        end
        srd_pkg::PH_GOT_ESC: begin
          if (b == srd_pkg::ESC_BYTE) begin
            blk_phase = srd_pkg::PH_GOT_ESC2;
          end else begin
            blk_phase = srd_pkg::PH_NORMAL;
            add_run(srd_pkg::ESC_BYTE, 8'd1);
            if (blk_phase != srd_pkg::PH_IDLE) add_run(b, 8'd1);
          end
        end
        srd_pkg::PH_GOT_ESC2: begin
          if (b == 8'd0) begin
            close_block(blk_written != 16'd0);
          end else begin
            run_count = b;
            blk_phase = srd_pkg::PH_GOT_COUNT;
          end
        end
        srd_pkg::PH_GOT_COUNT: begin
          blk_phase = srd_pkg::PH_NORMAL;
          add_run(b, run_count);
          run_count = '0;
        end
        default: blk_phase = srd_pkg::PH_IDLE;
      endcase
    end
    if (item_res.size() > 0) item_res[item_res.size() - 1].last = 1'b1;
    foreach (item_res[i]) runs_due.push_back(item_res[i]);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // acceptance first, so a same-edge result would still find its prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      decode_item(in_tuser, in_tdata);
      items_taken++;
      item_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      seen_run.value = out_tdata[7:0];
      seen_run.start = out_tdata[23:8];
      seen_run.len   = out_tdata[31:24];
      seen_run.done  = out_tdata[32];
      seen_run.ok    = out_tdata[33];
      seen_run.last  = out_tlast;
      if (runs_due.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none got %h last %b", $time,
                 out_tdata, out_tlast);
        fail_count++;
      end else begin
        due_run = runs_due.pop_front();
        check_field("run_value", due_run.value, seen_run.value);
        check_field("run_start", due_run.start, seen_run.start);
        check_field("run_length", due_run.len, seen_run.len);
        check_field("block_done", due_run.done, seen_run.done);
        check_field("block_ok", due_run.ok, seen_run.ok);
        check_field("last", due_run.last, seen_run.last);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        cur_item = feed_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= cur_item.data;
        in_tuser  <= cur_item.cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold) begin
      hold_left = 80;
      long_hold = 1'b0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(RX_OPEN, RX_COMB);
      rx_mode_left = $urandom_range(16, 128);
    end else begin
      rx_mode_left--;
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ((rx_cycle % 5) < 2);
      endcase
    end
  end

  task automatic push_item(input logic [1:0] cmd, input logic [7:0] data);
    stream_item_t it;
    it.cmd = cmd;
    it.data = data;
    feed_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_data(input logic [7:0] data);
    push_item(srd_pkg::CMD_DATA, data);
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || runs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_blk_len(input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    blk_len = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == srd_pkg::ESC_BYTE) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_block();
    int tokens;
    logic [7:0] cnt;
    if ($urandom_range(0, 9) != 0) push_item(srd_pkg::CMD_START, any_byte());
    tokens = $urandom_range(1, 20);
    repeat (tokens) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: push_data(plain_byte());
        8, 9, 10, 11: begin
          cnt = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
          if ($urandom_range(0, 1) == 0 && cnt != 8'd0) cnt = 8'($urandom_range(1, 8));
          push_data(srd_pkg::ESC_BYTE);
          push_data(srd_pkg::ESC_BYTE);
          push_data(cnt);
          if (cnt != 8'd0) push_data(any_byte());
        end
        12, 13, 14: begin
          push_data(srd_pkg::ESC_BYTE);
          push_data(plain_byte());
        end
        15: begin
          push_data(srd_pkg::ESC_BYTE);
          push_data(srd_pkg::ESC_BYTE);
          push_data(8'd0);
        end
        16: push_item(2'($urandom_range(0, 3)), any_byte());
        17: begin
          push_data(srd_pkg::ESC_BYTE);
          push_item(srd_pkg::CMD_END, any_byte());
        end
        default: push_item(srd_pkg::CMD_END, any_byte());
      endcase
    end
    if ($urandom_range(0, 1) == 0) push_item(srd_pkg::CMD_END, any_byte());
  endtask

  initial begin
    logic [15:0] len;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset length; commands while finished are dropped
    push_data(8'h33);
    push_item(srd_pkg::CMD_END, 8'h00);
    push_item(srd_pkg::CMD_UNUSED, 8'hFF);
    push_item(srd_pkg::CMD_START, 8'h00);
    push_data(8'h00);
    push_data(8'hFF);
    push_item(srd_pkg::CMD_END, 8'h00);
    wait_idle();

    write_blk_len(16'd8);
    push_item(srd_pkg::CMD_START, 8'h00);
    push_data(srd_pkg::ESC_BYTE);
    push_data(8'h12);
    push_data(srd_pkg::ESC_BYTE);
    push_data(srd_pkg::ESC_BYTE);
    push_data(8'd3);
    push_data(8'hAA);
    push_data(srd_pkg::ESC_BYTE);
    push_data(srd_pkg::ESC_BYTE);
    push_data(8'd255);
    push_data(8'h55);
    push_data(8'h44);
    // restart mid-block, then end with nothing written
    push_item(srd_pkg::CMD_START, 8'h00);
    push_data(8'h22);
    push_data(srd_pkg::ESC_BYTE);
    push_item(srd_pkg::CMD_START, 8'h00);
    push_item(srd_pkg::CMD_END, 8'h00);
    push_item(srd_pkg::CMD_START, 8'h00);
    push_data(srd_pkg::ESC_BYTE);
    push_item(srd_pkg::CMD_END, 8'h00);
    push_item(srd_pkg::CMD_START, 8'h00);
    push_data(srd_pkg::ESC_BYTE);
    push_data(srd_pkg::ESC_BYTE);
    push_data(8'd0);
    push_item(srd_pkg::CMD_START, 8'h00);
    push_data(8'h01);
    push_data(srd_pkg::ESC_BYTE);
    push_data(srd_pkg::ESC_BYTE);
    push_data(8'd0);
    wait_idle();

    // escape fills the block, following byte dropped
    write_blk_len(16'd1);
    push_item(srd_pkg::CMD_START, 8'h00);
    push_data(srd_pkg::ESC_BYTE);
    push_data(8'h11);
    wait_idle();

    // long receiver stall against a steady stream
    write_blk_len(16'hFFFF);
    long_hold = 1'b1;
    push_item(srd_pkg::CMD_START, 8'h00);
    repeat (40) push_data(plain_byte());
    wait_idle();

    // length lowered under the written count mid-block
    write_blk_len(16'd2);
    push_data(8'h10);
    push_item(srd_pkg::CMD_END, 8'h00);
    wait_idle();

    while (items_queued < 1260) begin
      case ($urandom_range(0, 9))
        0: len = 16'd1;
        1: len = 16'hFFFF;
        2: len = 16'($urandom_range(49, 700));
        default: len = 16'($urandom_range(2, 48));
      endcase
      write_blk_len(len);
      repeat ($urandom_range(1, 5)) push_block();
      wait_idle();
    end

    while (items_taken != items_queued || runs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && runs_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/srd_pkg.sv
rtl/snapshot_rle_decoder.sv
test/tb_snapshot_rle_decoder.sv
